@@ src/bti_pkg.sv @@
// ----------------------------------------------------------------------------
// bti_pkg: shared types and constants of the bilinear table interpolator
// Operation and register codes, datapath widths and the controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package bti_pkg;

	// input operation codes
	typedef enum logic [1:0] {
		OP_LOAD_BETA  = 2'd0,
		OP_LOAD_ANISO = 2'd1,
		OP_LOAD_GRID  = 2'd2,
		OP_QUERY      = 2'd3
	} op_t;

	// configuration register indexes
	localparam logic [1:0] REG_BETA_COUNT  = 2'd0;
	localparam logic [1:0] REG_ANISO_COUNT = 2'd1;
	localparam logic [1:0] REG_FUDGE_DIV   = 2'd2;

	localparam int DATA_W = 32;  // Q16.16 values
	localparam int NUM_W  = 48;  // divider numerator and quotient
	localparam int FRAC_W = 17;  // bin fraction, 0..65536
	localparam int ACC_W  = 48;  // row partial sums
	localparam int VAL_W  = 64;  // full bilinear sum

	localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

	typedef enum logic [14:0] {
		ST_IDLE = 15'h0001,
		ST_SRCH = 15'h0002,
		ST_CLMP = 15'h0004,
		ST_RLO  = 15'h0008,
		ST_RHI  = 15'h0010,
		ST_FB   = 15'h0020,
		ST_WB   = 15'h0040,
		ST_FA   = 15'h0080,
		ST_WA   = 15'h0100,
		ST_GRD  = 15'h0200,
		ST_VB   = 15'h0400,
		ST_VC   = 15'h0800,
		ST_VD   = 15'h1000,
		ST_FIN  = 15'h2000,
		ST_WF   = 15'h4000
	} state_t;

	// request to the shared divider
	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  num;
		logic [DATA_W-1:0] den;
	} div_req_t;

endpackage

`default_nettype wire

@@ src/bilinear_table_interpolator.sv @@
// ----------------------------------------------------------------------------
// bilinear_table_interpolator: two-axis table lookup with bilinear weighting
// Holds a beta axis, an anisotropy axis and a coefficient grid in memories;
// a query scans both axes, weights the four bin corners and divides the sum.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  command  | start, busy          | op, row, col, load_value, aniso_in, beta_in
//  result   | done (one cycle)     | coeff, below_table, saturated
//  config   | cfg_we               | cfg_index, cfg_wdata
//
//  A load is written when accepted and leaves the block idle. A query scans
//  n entries, where n is the larger of the two axis counts in use: the scan
//  reads both axis memories one entry a cycle, and the bit-serial divider is
//  run up to three times (two bin fractions, one final division).
//  Reset clears control and configuration only; table memories hold
//  whatever was last loaded. The result side cannot stall: each result is
//  shown for exactly one cycle on done.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_table_interpolator
	import bti_pkg::*;
#(
	parameter int MAX_BETA  = 64,
	parameter int MAX_ANISO = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// command transaction
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        op,
	input  wire logic [5:0]        row,
	input  wire logic [5:0]        col,
	input  wire logic [DATA_W-1:0] load_value,
	input  wire logic [DATA_W-1:0] aniso_in,
	input  wire logic [DATA_W-1:0] beta_in,
	// result transaction
	output logic                   done,
	output logic [DATA_W-1:0]      coeff,
	output logic                   below_table,
	output logic                   saturated,
	// configuration
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [DATA_W-1:0] cfg_wdata
);

	localparam int MAXN  = (MAX_BETA > MAX_ANISO) ? MAX_BETA : MAX_ANISO;
	localparam int CW    = $clog2(MAXN + 1);
	localparam int AW_B  = $clog2(MAX_BETA);
	localparam int AW_A  = $clog2(MAX_ANISO);
	localparam int GDEP  = MAX_BETA * MAX_ANISO;
	localparam int AW_G  = $clog2(GDEP);

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [6:0]        beta_count_q;
	logic [6:0]        aniso_count_q;
	logic [DATA_W-1:0] fudge_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_count_q  <= 7'd2;
			aniso_count_q <= 7'd2;
			fudge_q       <= 32'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BETA_COUNT:  beta_count_q  <= cfg_wdata[6:0];
				REG_ANISO_COUNT: aniso_count_q <= cfg_wdata[6:0];
				REG_FUDGE_DIV:   fudge_q       <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// effective counts: clamp into [2, MAX]
	logic [CW-1:0] nb, na, nmax;

	always_comb begin
		if (beta_count_q < 7'd2) begin
			nb = CW'(2);
		end else if (32'(beta_count_q) > MAX_BETA) begin
			nb = CW'(MAX_BETA);
		end else begin
			nb = CW'(beta_count_q);
		end
		if (aniso_count_q < 7'd2) begin
			na = CW'(2);
		end else if (32'(aniso_count_q) > MAX_ANISO) begin
			na = CW'(MAX_ANISO);
		end else begin
			na = CW'(aniso_count_q);
		end
		nmax = (nb > na) ? nb : na;
	end

	// ------------------------------------------------------------------
	// command acceptance and loads
	// ------------------------------------------------------------------
	state_t state_q;
	logic   accept;
	logic [31:0] row32, col32, lin_w32;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign row32   = 32'(row);
	assign col32   = 32'(col);
	assign lin_w32 = row32 * 32'(MAX_ANISO) + col32;

	logic we_b, we_a, we_g;

	assign we_b = accept && (op == OP_LOAD_BETA) && (row32 < MAX_BETA);
	assign we_a = accept && (op == OP_LOAD_ANISO) && (col32 < MAX_ANISO);
	assign we_g = accept && (op == OP_LOAD_GRID) && (row32 < MAX_BETA)
	              && (col32 < MAX_ANISO);

	// ------------------------------------------------------------------
	// memories
	// ------------------------------------------------------------------
	logic [31:0]       rb32, ra32, rg32;
	logic [DATA_W-1:0] beta_rd, aniso_rd, grid_rd;

	bti_ram #(.DEPTH(MAX_BETA), .WIDTH(DATA_W)) u_beta (
		.clk   (clk),
		.we    (we_b),
		.waddr (row32[AW_B-1:0]),
		.wdata (load_value),
		.raddr (rb32[AW_B-1:0]),
		.rdata (beta_rd)
	);

	bti_ram #(.DEPTH(MAX_ANISO), .WIDTH(DATA_W)) u_aniso (
		.clk   (clk),
		.we    (we_a),
		.waddr (col32[AW_A-1:0]),
		.wdata (load_value),
		.raddr (ra32[AW_A-1:0]),
		.rdata (aniso_rd)
	);

	bti_ram #(.DEPTH(GDEP), .WIDTH(DATA_W)) u_grid (
		.clk   (clk),
		.we    (we_g),
		.waddr (lin_w32[AW_G-1:0]),
		.wdata (load_value),
		.raddr (rg32[AW_G-1:0]),
		.rdata (grid_rd)
	);

	// ------------------------------------------------------------------
	// query datapath registers
	// ------------------------------------------------------------------
	logic [DATA_W-1:0] qb_q, qa_q;
	logic [CW-1:0]     cnt_q, idx_s1;
	logic              srch_s1;
	logic              bfound_q, afound_q;
	logic [CW-1:0]     bidx_q, aidx_q;
	logic [CW-1:0]     bi_q, ai_q;
	logic              clb_q, cla_q;
	logic [DATA_W-1:0] lob_q, hib_q, loa_q, hia_q;
	logic [FRAC_W-1:0] tb_q, ta_q;
	logic [2:0]        gk_q;
	logic              g_s1, g_s2;
	logic [1:0]        tag_s1, tag_s2;
	logic [DATA_W+FRAC_W-1:0] p_s2;
	logic [ACC_W-1:0]  r1_q, r2_q;
	logic [VAL_W+FRAC_W-1:0]  pv_q;
	logic [VAL_W-1:0]  v_q;

	// clamp the found indexes into the last bin
	logic [CW-1:0] bi_c, ai_c;
	logic          clb_c, cla_c;

	always_comb begin
		clb_c = (bidx_q >= nb - CW'(1));
		cla_c = (aidx_q >= na - CW'(1));
		bi_c  = clb_c ? nb - CW'(2) : bidx_q;
		ai_c  = cla_c ? na - CW'(2) : aidx_q;
	end

	// read addresses
	logic [31:0] g_row, g_col;

	always_comb begin
		g_row = 32'(bi_q) + 32'(gk_q[1]);
		g_col = 32'(ai_q) + 32'(gk_q[0]);
		rg32  = g_row * 32'(MAX_ANISO) + g_col;
		case (state_q)
			ST_CLMP: begin
				rb32 = 32'(bi_c);
				ra32 = 32'(ai_c);
			end
			ST_RLO: begin
				rb32 = 32'(bi_q) + 32'd1;
				ra32 = 32'(ai_q) + 32'd1;
			end
			default: begin
				rb32 = 32'(cnt_q);
				ra32 = 32'(cnt_q);
			end
		endcase
	end

	// bin fraction set-up: clamp the query into [lo, hi]
	logic [DATA_W-1:0] fq, flo, fhi, fqc;
	logic              fflat;

	always_comb begin
		if (state_q == ST_FA) begin
			fq  = cla_q ? hia_q : qa_q;
			flo = loa_q;
			fhi = hia_q;
		end else begin
			fq  = clb_q ? hib_q : qb_q;
			flo = lob_q;
			fhi = hib_q;
		end
		fflat = (fhi <= flo);
		if (fq < flo) begin
			fqc = flo;
		end else if (fq > fhi) begin
			fqc = fhi;
		end else begin
			fqc = fq;
		end
	end

	// shared divider
	div_req_t          dreq;
	logic              ddone;
	logic [NUM_W-1:0]  dquo;

	always_comb begin
		dreq.start = 1'b0;
		dreq.num   = {fqc - flo, 16'h0000};
		dreq.den   = fhi - flo;
		case (state_q)
			ST_FB, ST_FA: dreq.start = !fflat;
			ST_FIN: begin
				dreq.start = 1'b1;
				dreq.num   = v_q[VAL_W-1:16];
				dreq.den   = (fudge_q == '0) ? DATA_W'(1) : fudge_q;
			end
			default: ;
		endcase
	end

	bti_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.done   (ddone),
		.quo    (dquo)
	);

	// corner weight for the grid read now returning
	logic [FRAC_W-1:0] gw;

	assign gw = tag_s1[0] ? ta_q : FRAC_ONE - ta_q;

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			done        <= 1'b0;
			srch_s1     <= 1'b0;
			g_s1        <= 1'b0;
			g_s2        <= 1'b0;
			bfound_q    <= 1'b0;
			afound_q    <= 1'b0;
			cnt_q       <= '0;
			gk_q        <= '0;
		end else begin
			done    <= 1'b0;
			srch_s1 <= 1'b0;
			g_s1    <= 1'b0;
			g_s2    <= g_s1;
			case (state_q)
				ST_IDLE: begin
					if (accept && (op == OP_QUERY)) begin
						state_q  <= ST_SRCH;
						cnt_q    <= '0;
						bfound_q <= 1'b0;
						afound_q <= 1'b0;
					end
				end
				ST_SRCH: begin
					// issue one read per axis a cycle, compare the data in the next cycle
					if (cnt_q < nmax) begin
						srch_s1 <= 1'b1;
						cnt_q   <= cnt_q + CW'(1);
					end else begin
						state_q <= ST_CLMP;
					end
					if (srch_s1 && (idx_s1 < nb) && (qb_q >= beta_rd)) begin
						bfound_q <= 1'b1;
					end
					if (srch_s1 && (idx_s1 < na) && (qa_q >= aniso_rd)) begin
						afound_q <= 1'b1;
					end
				end
				ST_CLMP: begin
					if (!bfound_q || !afound_q) begin
						done    <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_RLO;
					end
				end
				ST_RLO:  state_q <= ST_RHI;
				ST_RHI:  state_q <= ST_FB;
				ST_FB:   state_q <= fflat ? ST_FA : ST_WB;
				ST_WB: begin
					if (ddone) begin
						state_q <= ST_FA;
					end
				end
				ST_FA: begin
					if (fflat) begin
						state_q <= ST_GRD;
						gk_q    <= '0;
					end else begin
						state_q <= ST_WA;
					end
				end
				ST_WA: begin
					if (ddone) begin
						state_q <= ST_GRD;
						gk_q    <= '0;
					end
				end
				ST_GRD: begin
					// four corner reads, multiply, then accumulate
					gk_q <= gk_q + 3'd1;
					if (gk_q < 3'd4) begin
						g_s1 <= 1'b1;
					end
					if (gk_q == 3'd5) begin
						state_q <= ST_VB;
					end
				end
				ST_VB:  state_q <= ST_VC;
				ST_VC:  state_q <= ST_VD;
				ST_VD:  state_q <= ST_FIN;
				ST_FIN: state_q <= ST_WF;
				ST_WF: begin
					if (ddone) begin
						done    <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers of the query
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		tag_s1 <= gk_q[1:0];
		tag_s2 <= tag_s1;
		p_s2   <= grid_rd * gw;
		case (state_q)
			ST_IDLE: begin
				qb_q <= beta_in;
				qa_q <= aniso_in;
			end
			ST_SRCH: begin
				if (srch_s1 && (idx_s1 < nb) && (qb_q >= beta_rd)) begin
					bidx_q <= idx_s1;
				end
				if (srch_s1 && (idx_s1 < na) && (qa_q >= aniso_rd)) begin
					aidx_q <= idx_s1;
				end
			end
			ST_CLMP: begin
				bi_q  <= bi_c;
				ai_q  <= ai_c;
				clb_q <= clb_c;
				cla_q <= cla_c;
				// below either axis: answer zero
				coeff       <= '0;
				below_table <= 1'b1;
				saturated   <= 1'b0;
			end
			ST_RLO: begin
				lob_q <= beta_rd;
				loa_q <= aniso_rd;
			end
			ST_RHI: begin
				hib_q <= beta_rd;
				hia_q <= aniso_rd;
			end
			ST_FB: begin
				tb_q <= '0;
			end
			ST_WB: begin
				if (ddone) begin
					tb_q <= dquo[FRAC_W-1:0];
				end
			end
			ST_FA: begin
				ta_q <= '0;
				r1_q <= '0;
				r2_q <= '0;
			end
			ST_WA: begin
				if (ddone) begin
					ta_q <= dquo[FRAC_W-1:0];
				end
			end
			ST_GRD: begin
				if (g_s2) begin
					if (tag_s2[1]) begin
						r2_q <= r2_q + p_s2[ACC_W-1:0];
					end else begin
						r1_q <= r1_q + p_s2[ACC_W-1:0];
					end
				end
			end
			ST_VB: pv_q <= r1_q * (FRAC_ONE - tb_q);
			ST_VC: begin
				v_q  <= pv_q[VAL_W-1:0];
				pv_q <= r2_q * tb_q;
			end
			ST_VD: v_q <= v_q + pv_q[VAL_W-1:0];
			ST_WF: begin
				if (ddone) begin
					below_table <= 1'b0;
					// saturate when the quotient does not fit 32 bits
					if (dquo[NUM_W-1:DATA_W] != '0) begin
						coeff     <= '1;
						saturated <= 1'b1;
					end else begin
						coeff     <= dquo[DATA_W-1:0];
						saturated <= 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == ST_IDLE))
		else $error("result strobe outside idle");

	a_below_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && below_table) |-> ((coeff == '0) && !saturated))
		else $error("below-table result not zero");

	a_sat_ones: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |-> (coeff == '1))
		else $error("saturated result not all ones");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op == OP_QUERY)) |=> busy)
		else $error("query accepted without going busy");

endmodule

`default_nettype wire

@@ src/bti_ram.sv @@
// ----------------------------------------------------------------------------
// bti_ram: single-port-write, single-port-read synchronous memory
// One write and one registered read a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bti_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ src/bti_div.sv @@
// ----------------------------------------------------------------------------
// bti_div: bit-serial restoring divider
// 48-bit numerator by 32-bit divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bti_div
	import bti_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire div_req_t          req,
	output logic                   done,
	output logic [NUM_W-1:0]       quo
);

	localparam int CNT_W = $clog2(NUM_W);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [NUM_W-1:0]  num_q;
	logic [DATA_W-1:0] den_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W:0]   sh;
	logic [DATA_W:0]   diff;
	logic              ge;

	assign sh   = {rem_q, num_q[NUM_W-1]};
	assign ge   = sh >= {1'b0, den_q};
	assign diff = sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= ge ? diff[DATA_W-1:0] : sh[DATA_W-1:0];
			quo   <= {quo[NUM_W-2:0], ge};
		end
	end

endmodule

`default_nettype wire
